@@ rtl/vrt_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// vrt_pkg
// Types, codes and fixed widths shared by the voxel ray walker.
// ---------------------------------------------------------------------------
package vrt_pkg;

  localparam int DIR_BITS     = 6;
  localparam int MAG_BITS     = 5;
  localparam int WSZ_BITS     = 11;
  localparam int STEP_BITS    = 10;
  localparam int TIME_BITS    = 17;
  localparam int CNT_BITS     = 6;
  localparam int CFG_IDX_BITS = 2;
  localparam int MAX_DIR      = 21;
  localparam int MAX_RESULTS  = 63;
  localparam logic [WSZ_BITS-1:0] WSZ_RESET = WSZ_BITS'(1024);

  typedef enum logic [1:0] {
    CAUSE_DEST = 2'd0,
    CAUSE_EXIT = 2'd1,
    CAUSE_ZERO = 2'd2
  } cause_t;

  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_WALK
  } state_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WSX = 2'd0,
    CFG_WSY = 2'd1
  } cfg_reg_t;

  // per-axis walk state handed to the step unit
  typedef struct packed {
    logic [2:0]                     on;
    logic [2:0]                     neg;
    logic [2:0][TIME_BITS-1:0]      crossing;
    logic [2:0][STEP_BITS-1:0]      step;
  } axis_state_t;

  function automatic logic signed [DIR_BITS-1:0] sat_dir(input logic signed [DIR_BITS-1:0] d);
    logic signed [DIR_BITS-1:0] r;
    r = d;
    if (d > DIR_BITS'(MAX_DIR)) r = DIR_BITS'(MAX_DIR);
    if (d < -DIR_BITS'(MAX_DIR)) r = -DIR_BITS'(MAX_DIR);
    return r;
  endfunction

  function automatic logic [MAG_BITS-1:0] mag(input logic signed [DIR_BITS-1:0] d);
    logic signed [DIR_BITS-1:0] n;
    n = -d;
    return d[DIR_BITS-1] ? n[MAG_BITS-1:0] : d[MAG_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/vrt_step_unit.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// vrt_step_unit
// Picks the axis with the earliest boundary crossing, advances its crossing
// time and coordinate, and checks the entered voxel against the world.
// ---------------------------------------------------------------------------
module vrt_step_unit #(
  parameter int CW = 12
) (
  input  vrt_pkg::axis_state_t                 ast,
  input  logic signed [CW-1:0]                 walk_x,
  input  logic signed [CW-1:0]                 walk_y,
  input  logic signed [CW-1:0]                 walk_z,
  input  logic [vrt_pkg::WSZ_BITS-1:0]         wsx,
  input  logic [vrt_pkg::WSZ_BITS-1:0]         wsy,
  output vrt_pkg::axis_t                       axis,
  output logic [vrt_pkg::TIME_BITS-1:0]        cross_new,
  output logic signed [CW-1:0]                 nxt_x,
  output logic signed [CW-1:0]                 nxt_y,
  output logic signed [CW-1:0]                 nxt_z,
  output logic                                 nxt_in
);
  import vrt_pkg::*;

  localparam int WW = CW + WSZ_BITS;

  logic ex_xy, ex_xz, ey_z;
  logic signed [CW-1:0] delta;

  assign ex_xy = ast.on[0] && (!ast.on[1] || ast.crossing[0] < ast.crossing[1]);
  assign ex_xz = ast.on[0] && (!ast.on[2] || ast.crossing[0] < ast.crossing[2]);
  assign ey_z  = ast.on[1] && (!ast.on[2] || ast.crossing[1] < ast.crossing[2]);

  always_comb begin
    if (ex_xy) begin
      axis = ex_xz ? AX_X : AX_Z;
    end else begin
      axis = ey_z ? AX_Y : AX_Z;
    end
  end

  assign cross_new = ast.crossing[axis] + TIME_BITS'(ast.step[axis]);
  assign delta     = ast.neg[axis] ? {CW{1'b1}} : CW'(1);

  assign nxt_x = (axis == AX_X) ? walk_x + delta : walk_x;
  assign nxt_y = (axis == AX_Y) ? walk_y + delta : walk_y;
  assign nxt_z = (axis == AX_Z) ? walk_z + delta : walk_z;

  assign nxt_in = !nxt_x[CW-1] && !nxt_y[CW-1] && !nxt_z[CW-1]
               && (WW'($unsigned(nxt_x)) < WW'(wsx))
               && (WW'($unsigned(nxt_y)) < WW'(wsy));

endmodule
`default_nettype wire

@@ rtl/voxel_ray_traversal_3d.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// voxel_ray_traversal_3d
// Setup: the shared multiplier forms one crossing time per axis, then the
//   walk takes one step a cycle while the output is not stalled.
// Handshake: in_ready is high only while idle, so a new ray is taken only
//   once the walk has ended. Output stalls hold the walk.
// Reset: synchronous; clears the sequencer and output valid, sizes to 1024.
// ---------------------------------------------------------------------------
module voxel_ray_traversal_3d #(
  parameter int COORD_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vrt_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [vrt_pkg::WSZ_BITS-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [COORD_BITS-1:0]               origin_x,
  input  logic [COORD_BITS-1:0]               origin_y,
  input  logic [COORD_BITS-1:0]               origin_z,
  input  logic signed [vrt_pkg::DIR_BITS-1:0] dir_x,
  input  logic signed [vrt_pkg::DIR_BITS-1:0] dir_y,
  input  logic signed [vrt_pkg::DIR_BITS-1:0] dir_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [COORD_BITS-1:0]               voxel_x,
  output logic [COORD_BITS-1:0]               voxel_y,
  output logic [COORD_BITS:0]                 voxel_z,
  output logic                                voxel_valid,
  output logic                                last,
  output logic [1:0]                          stop_cause
);
  import vrt_pkg::*;

  localparam int CW = COORD_BITS + 3;

  state_t state, state_next;

  logic [WSZ_BITS-1:0]  wsx, wsy;
  axis_state_t          ast;
  logic [2:0][MAG_BITS-1:0] amag;
  logic signed [CW-1:0] walk_x, walk_y, walk_z;
  logic signed [CW-1:0] dest_x, dest_y, dest_z;
  logic [1:0]           sidx;
  logic [CNT_BITS-1:0]  cnt;
  logic                 pend_v, pend_final;

  logic signed [DIR_BITS-1:0] dsx, dsy, dsz;
  logic [MAG_BITS-1:0]        mul_a, mul_b;
  logic [2*MAG_BITS-1:0]      prod;

  axis_t                 axis;
  logic [TIME_BITS-1:0]  cross_new;
  logic signed [CW-1:0]  nxt_x, nxt_y, nxt_z;
  logic                  nxt_in;

  logic   out_free, take_step, emit;
  logic   e_valid, e_last, e_pos;
  cause_t e_cause;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;

  assign dsx = sat_dir(dir_x);
  assign dsy = sat_dir(dir_y);
  assign dsz = sat_dir(dir_z);

  // setup: crossing time of axis k is the product of the other magnitudes, a zero magnitude counting as 1
  always_comb begin
    logic [MAG_BITS-1:0] fx, fy, fz;
    fx = ast.on[0] ? amag[0] : MAG_BITS'(1);
    fy = ast.on[1] ? amag[1] : MAG_BITS'(1);
    fz = ast.on[2] ? amag[2] : MAG_BITS'(1);
    case (sidx)
      2'd0:    begin mul_a = fy; mul_b = fz; end
      2'd1:    begin mul_a = fx; mul_b = fz; end
      default: begin mul_a = fx; mul_b = fy; end
    endcase
  end

  assign prod = mul_a * mul_b;

  vrt_step_unit #(.CW(CW)) u_step (
    .ast       (ast),
    .walk_x    (walk_x),
    .walk_y    (walk_y),
    .walk_z    (walk_z),
    .wsx       (wsx),
    .wsy       (wsy),
    .axis      (axis),
    .cross_new (cross_new),
    .nxt_x     (nxt_x),
    .nxt_y     (nxt_y),
    .nxt_z     (nxt_z),
    .nxt_in    (nxt_in)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    take_step  = 1'b0;
    emit       = 1'b0;
    e_valid    = 1'b0;
    e_last     = 1'b0;
    e_pos      = 1'b0;
    e_cause    = CAUSE_DEST;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SETUP;
      end
      S_SETUP: begin
        if (sidx == 2'd2) state_next = S_WALK;
      end
      S_WALK: begin
        if (ast.on == 3'b000) begin
          if (out_free) begin
            emit = 1'b1; e_last = 1'b1; e_cause = CAUSE_ZERO;
            state_next = S_IDLE;
          end
        end else if (pend_final) begin
          if (out_free) begin
            emit = 1'b1; e_valid = 1'b1; e_pos = 1'b1; e_last = 1'b1;
            state_next = S_IDLE;
          end
        end else if (!pend_v) begin
          if (!nxt_in) begin
            if (out_free) begin
              emit = 1'b1; e_last = 1'b1; e_cause = CAUSE_EXIT;
              state_next = S_IDLE;
            end
          end else begin
            take_step = 1'b1;
          end
        end else if (out_free) begin
          emit = 1'b1; e_valid = 1'b1; e_pos = 1'b1;
          if (!nxt_in) begin
            e_last = 1'b1; e_cause = CAUSE_EXIT;
            state_next = S_IDLE;
          end else begin
            take_step = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wsx        <= WSZ_RESET;
      wsy        <= WSZ_RESET;
      pend_v     <= 1'b0;
      pend_final <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WSX: wsx <= cfg_data;
          CFG_WSY: wsy <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        pend_v     <= 1'b0;
        pend_final <= 1'b0;
      end else if (take_step) begin
        pend_v     <= 1'b1;
        pend_final <= (nxt_x == dest_x && nxt_y == dest_y && nxt_z == dest_z)
                   || (cnt == CNT_BITS'(MAX_RESULTS - 1));
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ast.on   <= {dsz != '0, dsy != '0, dsx != '0};
      ast.neg  <= {dsz[DIR_BITS-1], dsy[DIR_BITS-1], dsx[DIR_BITS-1]};
      amag     <= {mag(dsz), mag(dsy), mag(dsx)};
      walk_x   <= CW'({1'b0, origin_x});
      walk_y   <= CW'({1'b0, origin_y});
      walk_z   <= CW'({1'b0, origin_z});
      dest_x   <= CW'({1'b0, origin_x}) + CW'(dsx);
      dest_y   <= CW'({1'b0, origin_y}) + CW'(dsy);
      dest_z   <= CW'({1'b0, origin_z}) + CW'(dsz);
      sidx     <= 2'd0;
      cnt      <= '0;
    end else if (state == S_SETUP) begin
      ast.crossing[sidx] <= TIME_BITS'(prod);
      ast.step[sidx]     <= STEP_BITS'({prod, 1'b0});
      sidx               <= sidx + 2'd1;
    end else if (take_step) begin
      ast.crossing[axis] <= cross_new;
      walk_x             <= nxt_x;
      walk_y             <= nxt_y;
      walk_z             <= nxt_z;
      cnt                <= cnt + CNT_BITS'(1);
    end
    if (emit) begin
      voxel_x     <= e_pos ? walk_x[COORD_BITS-1:0] : '0;
      voxel_y     <= e_pos ? walk_y[COORD_BITS-1:0] : '0;
      voxel_z     <= e_pos ? walk_z[COORD_BITS:0] : '0;
      voxel_valid <= e_valid;
      last        <= e_last;
      stop_cause  <= e_cause;
    end
  end

endmodule
`default_nettype wire

@@ rtl/vrt_checker.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// vrt_checker
// Port-level checks on the result channel of the voxel ray walker.
// ---------------------------------------------------------------------------
module vrt_checker #(
  parameter int COORD_BITS = 10
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [COORD_BITS-1:0] voxel_x,
  input wire logic [COORD_BITS-1:0] voxel_y,
  input wire logic [COORD_BITS:0]   voxel_z,
  input wire logic                  voxel_valid,
  input wire logic                  last,
  input wire logic [1:0]            stop_cause
);
  import vrt_pkg::*;

  // an empty walk is always a single, final beat
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !voxel_valid |-> last)
    else $error("empty result not marked last");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !voxel_valid |-> voxel_x == '0 && voxel_y == '0 && voxel_z == '0)
    else $error("empty result carries coordinates");

  a_cause_mid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> stop_cause == CAUSE_DEST && voxel_valid)
    else $error("non-final beat with stop cause or empty");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(voxel_x) && $stable(voxel_y)
      && $stable(voxel_z) && $stable(last) && $stable(stop_cause))
    else $error("stalled result beat changed");

endmodule

bind voxel_ray_traversal_3d vrt_checker #(.COORD_BITS(COORD_BITS)) u_vrt_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .voxel_x     (voxel_x),
  .voxel_y     (voxel_y),
  .voxel_z     (voxel_z),
  .voxel_valid (voxel_valid),
  .last        (last),
  .stop_cause  (stop_cause)
);
`default_nettype wire
